// ===== src/clock_page_replacement_unit_macros.svh =====
// assertion helpers used by cpr_ctrl, clocked on clk_i and disabled in reset
`ifndef CLOCK_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define CLOCK_PAGE_REPLACEMENT_UNIT_MACROS_SVH

// condition that must hold at every clock edge
`define CPR_ASSERT_COMB(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define CPR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cpr_pkg.sv =====
package cpr_pkg;

  localparam int TBL_W = 4;
  localparam int ENT_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALGORITHM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 2'd2;

  // command codes
  localparam logic [1:0] MODE_TOUCH = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_SELECT = 2'd2;

  // flag bit positions
  localparam int FLAG_P = 0;
  localparam int FLAG_U = 1;
  localparam int FLAG_D = 2;

  // passes are counted from zero
  localparam logic [1:0] PASS_CLEAR = 2'd1;
  localparam logic [1:0] PASS_LAST = 2'd3;

  typedef logic [2:0] flags_t;

  typedef struct packed {
    logic       algorithm;
    logic [4:0] tables_in_use;
    logic [6:0] entries_per_table;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{algorithm: 1'b0, tables_in_use: 5'd1,
                                 entries_per_table: 7'd64};

  typedef struct packed {
    logic [1:0]       mode;
    logic [TBL_W-1:0] page_table;
    logic [ENT_W-1:0] page_entry;
    logic             write_access;
  } cmd_t;

  typedef struct packed {
    logic             victim_found;
    logic [TBL_W-1:0] victim_table;
    logic [ENT_W-1:0] victim_entry;
    logic             needs_writeback;
  } res_t;

  // present is checked by the caller
  function automatic logic is_candidate(flags_t f, logic alg, logic [1:0] pass);
    logic r;
    if (f[FLAG_U]) begin
      r = 1'b0;
    end else if (!alg) begin
      r = 1'b1;
    end else if (f[FLAG_D]) begin
      r = pass[0];
    end else begin
      r = !pass[0];
    end
    return r;
  endfunction

endpackage

// ===== src/cpr_flag_mem.sv =====
module cpr_flag_mem #(
  parameter int AW = 10
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  cpr_pkg::flags_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output cpr_pkg::flags_t rdata_o
);
  import cpr_pkg::*;

  flags_t mem [2**AW];
  flags_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/cpr_ctrl.sv =====
`include "clock_page_replacement_unit_macros.svh"

module cpr_ctrl #(
  parameter int MAX_TABLES = 16,
  parameter int MAX_ENTRIES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cpr_pkg::cfg_t cfg_i,
  input  logic          start_i,
  input  cpr_pkg::cmd_t cmd_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output cpr_pkg::res_t res_o
);
  import cpr_pkg::*;

  localparam int TW = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int AW = TW + EW;
  localparam int NTW = TW + 1;
  localparam int NEW = EW + 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_RMW = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0] state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] addr_q, addr_d;
  logic rel_q, rel_d;
  logic wr_q, wr_d;
  logic [NTW-1:0] st_q, st_d;
  logic [NEW-1:0] se_q, se_d;
  logic [1:0] pass_q, pass_d;
  logic rd_vld_q, rd_vld_d;
  logic [TW-1:0] vt_q, vt_d;
  logic [EW-1:0] ve_q, ve_d;
  logic [TW-1:0] ct_q, ct_d;
  logic [EW-1:0] ce_q, ce_d;
  logic res_valid_q, res_valid_d;
  res_t res_q, res_d;

  logic [NTW-1:0] nt;
  logic [NEW-1:0] ne;
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  flags_t mem_wdata, f;
  logic in_rng;

  cpr_flag_mem #(.AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (f)
  );

  // clamp the configured geometry
  always_comb begin
    if (cfg_i.tables_in_use == '0) begin
      nt = NTW'(1);
    end else if (32'(cfg_i.tables_in_use) > MAX_TABLES) begin
      nt = NTW'(MAX_TABLES);
    end else begin
      nt = NTW'(cfg_i.tables_in_use);
    end
    if (cfg_i.entries_per_table == '0) begin
      ne = NEW'(1);
    end else if (32'(cfg_i.entries_per_table) > MAX_ENTRIES) begin
      ne = NEW'(MAX_ENTRIES);
    end else begin
      ne = NEW'(cfg_i.entries_per_table);
    end
  end

  assign in_rng = (32'(cmd_i.page_table) < 32'(nt)) && (32'(cmd_i.page_entry) < 32'(ne));

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    addr_d = addr_q;
    rel_d = rel_q;
    wr_d = wr_q;
    st_d = st_q;
    se_d = se_q;
    pass_d = pass_q;
    rd_vld_d = 1'b0;
    vt_d = vt_q;
    ve_d = ve_q;
    ct_d = ct_q;
    ce_d = ce_q;
    res_valid_d = 1'b0;
    res_d = '0;
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_q;
        clr_d = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          unique case (cmd_i.mode)
            MODE_TOUCH, MODE_RELEASE: begin
              if (in_rng) begin
                addr_d = {TW'(cmd_i.page_table), EW'(cmd_i.page_entry)};
                mem_raddr = addr_d;
                rel_d = (cmd_i.mode == MODE_RELEASE);
                wr_d = cmd_i.write_access;
                state_d = S_RMW;
              end else begin
                res_valid_d = 1'b1;
              end
            end
            MODE_SELECT: begin
              st_d = NTW'(ct_q);
              se_d = NEW'(ce_q);
              pass_d = '0;
              state_d = S_SCAN;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_RMW: begin
        mem_we = 1'b1;
        mem_waddr = addr_q;
        if (rel_q) begin
          mem_wdata = '0;
          res_d.needs_writeback = f[FLAG_D];
        end else begin
          mem_wdata = f;
          mem_wdata[FLAG_P] = 1'b1;
          mem_wdata[FLAG_U] = 1'b1;
          mem_wdata[FLAG_D] = f[FLAG_D] | wr_q;
        end
        res_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      S_SCAN: begin
        // evaluate the entry read last cycle while the next read goes out
        if (rd_vld_q && f[FLAG_P] && is_candidate(f, cfg_i.algorithm, pass_q)) begin
          res_valid_d = 1'b1;
          res_d.victim_found = 1'b1;
          res_d.victim_table = TBL_W'(vt_q);
          res_d.victim_entry = ENT_W'(ve_q);
          res_d.needs_writeback = f[FLAG_D];
          if ((NEW'(ve_q) + NEW'(1)) >= ne) begin
            ce_d = '0;
            ct_d = ((NTW'(vt_q) + NTW'(1)) >= nt) ? '0 : vt_q + TW'(1);
          end else begin
            ct_d = vt_q;
            ce_d = ve_q + EW'(1);
          end
          state_d = S_IDLE;
        end else begin
          if (rd_vld_q && f[FLAG_P] && (!cfg_i.algorithm || pass_q == PASS_CLEAR)) begin
            mem_we = 1'b1;
            mem_waddr = {vt_q, ve_q};
            mem_wdata = f;
            mem_wdata[FLAG_U] = 1'b0;
          end
          if (st_q >= nt) begin
            if (pass_q == PASS_LAST) begin
              res_valid_d = 1'b1;
              state_d = S_IDLE;
            end else begin
              pass_d = pass_q + 2'd1;
              st_d = '0;
              se_d = '0;
            end
          end else if (se_q >= ne) begin
            st_d = st_q + NTW'(1);
            se_d = '0;
          end else begin
            mem_raddr = {st_q[TW-1:0], se_q[EW-1:0]};
            rd_vld_d = 1'b1;
            vt_d = st_q[TW-1:0];
            ve_d = se_q[EW-1:0];
            se_d = se_q + NEW'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      pass_q <= '0;
      rd_vld_q <= 1'b0;
      ct_q <= '0;
      ce_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      pass_q <= pass_d;
      rd_vld_q <= rd_vld_d;
      ct_q <= ct_d;
      ce_q <= ce_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    rel_q <= rel_d;
    wr_q <= wr_d;
    st_q <= st_d;
    se_q <= se_d;
    vt_q <= vt_d;
    ve_q <= ve_d;
    res_q <= res_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

  `CPR_ASSERT_IMPL(a_res_in_idle, res_valid_q, state_q == S_IDLE, "result outside idle")
  `CPR_ASSERT_COMB(a_clear_quiet, !(state_q == S_CLEAR && res_valid_q), "result during clear")
  `CPR_ASSERT_IMPL(a_read_in_scan, rd_vld_q, state_q == S_SCAN, "scan read outside scan")
  `CPR_ASSERT_NEXT(a_rmw_result, state_q == S_RMW, res_valid_q, "touch or release lost")

endmodule

// ===== src/clock_page_replacement_unit.sv =====
// channel   direction  signals                              transaction
// command   in         start_i, cmd_i                       start_i && !busy_o
// result    out        result_valid_o, result_o             one-cycle strobe
// config    in         cfg_we_i, cfg_idx_i, cfg_data_i      cfg_we_i high
//
// after reset a clearing sweep runs over 2**(clog2(MAX_TABLES)+clog2(MAX_ENTRIES))
// flag words, one per cycle (1024 by default), with busy_o high.
// touch and release do a read-modify-write on the flag memory: the flags are read,
// then written back and the result registered; out-of-range and unknown commands
// answer the next cycle. select reads one entry per cycle within a table, with a
// step between tables: up to four passes, fewer when a victim turns up early.
// results cannot be stalled; busy_o falls in the cycle the result is shown.
module clock_page_replacement_unit #(
  parameter int MAX_TABLES = 16,
  parameter int MAX_ENTRIES = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  cpr_pkg::cmd_t                       cmd_i,
  output logic                                busy_o,
  output logic                                result_valid_o,
  output cpr_pkg::res_t                       result_o,
  input  logic                                cfg_we_i,
  input  logic [cpr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [cpr_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import cpr_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ALGORITHM: cfg_q.algorithm <= cfg_data_i[0];
        REG_TABLES: cfg_q.tables_in_use <= cfg_data_i[4:0];
        REG_ENTRIES: cfg_q.entries_per_table <= cfg_data_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  cpr_ctrl #(
    .MAX_TABLES  (MAX_TABLES),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .busy_o      (busy_o),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import cpr_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int PAGE_TABLES = 16;
  localparam int TABLE_ENTRIES = 64;
  localparam int PHASES = 17;
  localparam int SETTLE_CYCLES = 4;
  localparam int TIMEOUT_CYCLES = 40_000_000;
  localparam logic [1:0] MODE_UNKNOWN = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    cmd_t                  cmd;
    int                    gap;
  } backlog_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  cmd_t cmd_i = '0;
  logic busy_o;
  logic result_valid_o;
  res_t result_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  backlog_item_t command_backlog[$];
  res_t predicted_results[$];
  int issued_count = 0;
  int received_count = 0;
  int error_count = 0;
  int gap_count = 0;
  int settle_count = 0;

  // shadow of the flag memory, cursor and registers
  flags_t page_flags [PAGE_TABLES*TABLE_ENTRIES];
  int cursor_table = 0;
  int cursor_entry = 0;
  logic modified_clock = CFG_RESET.algorithm;
  logic [4:0] tables_reg = CFG_RESET.tables_in_use;
  logic [6:0] entries_reg = CFG_RESET.entries_per_table;

  clock_page_replacement_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (cmd_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #(CLK_PERIOD/2) clk_i = ~clk_i;
  end

  function automatic int active_tables();
    if (tables_reg == 0) return 1;
    if (tables_reg > PAGE_TABLES) return PAGE_TABLES;
    return int'(tables_reg);
  endfunction

  function automatic int active_entries();
    if (entries_reg == 0) return 1;
    if (entries_reg > TABLE_ENTRIES) return TABLE_ENTRIES;
    return int'(entries_reg);
  endfunction

  // passes count from 1; with the modified clock, odd passes take clean pages, even passes dirty ones
  function automatic bit replaceable(flags_t f, int pass);
    if (f[FLAG_U]) return 1'b0;
    if (!modified_clock) return 1'b1;
    if (f[FLAG_D]) return (pass % 2) == 0;
    return (pass % 2) == 1;
  endfunction

  function automatic bit sweep_pass(input int pass, input int first_tbl, input int first_ent,
                                    output int vt, output int ve);
    int nt;
    int ne;
    int idx;
    flags_t f;
    nt = active_tables();
    ne = active_entries();
    vt = 0;
    ve = 0;
    for (int t = first_tbl; t < nt; t++) begin
      for (int e = (t == first_tbl) ? first_ent : 0; e < ne; e++) begin
        idx = t * TABLE_ENTRIES + e;
        f = page_flags[idx];
        if (f[FLAG_P]) begin
          if (replaceable(f, pass)) begin
            vt = t;
            ve = e;
            return 1'b1;
          end
          // second chance: plain clock always, modified clock only on its second pass
          if (!modified_clock || pass == 2) page_flags[idx][FLAG_U] = 1'b0;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic res_t predict_outcome(cmd_t c);
    res_t r;
    int nt;
    int ne;
    int idx;
    int vt;
    int ve;
    bit any_present;
    bit found;
    r = '0;
    nt = active_tables();
    ne = active_entries();
    case (c.mode)
      MODE_TOUCH, MODE_RELEASE: begin
        if (c.page_table < nt && c.page_entry < ne) begin
          idx = c.page_table * TABLE_ENTRIES + c.page_entry;
          if (c.mode == MODE_TOUCH) begin
            page_flags[idx][FLAG_P] = 1'b1;
            page_flags[idx][FLAG_U] = 1'b1;
            if (c.write_access) page_flags[idx][FLAG_D] = 1'b1;
          end else begin
            r.needs_writeback = page_flags[idx][FLAG_D];
            page_flags[idx] = '0;
          end
        end
      end
      MODE_SELECT: begin
        any_present = 1'b0;
        for (int t = 0; t < nt; t++)
          for (int e = 0; e < ne; e++)
            if (page_flags[t*TABLE_ENTRIES+e][FLAG_P]) any_present = 1'b1;
        if (any_present) begin
          found = 1'b0;
          for (int pass = 1; pass <= 4 && !found; pass++)
            found = sweep_pass(pass, (pass == 1) ? cursor_table : 0,
                               (pass == 1) ? cursor_entry : 0, vt, ve);
          if (found) begin
            r.victim_found = 1'b1;
            r.victim_table = vt[TBL_W-1:0];
            r.victim_entry = ve[ENT_W-1:0];
            r.needs_writeback = page_flags[vt*TABLE_ENTRIES+ve][FLAG_D];
            if (ve + 1 >= ne) begin
              cursor_entry = 0;
              cursor_table = (vt + 1 >= nt) ? 0 : vt + 1;
            end else begin
              cursor_table = vt;
              cursor_entry = ve + 1;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap(bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cmd_t build_cmd(logic [1:0] mode, int tbl, int ent, logic wr);
    cmd_t c;
    c.mode = mode;
    c.page_table = tbl[TBL_W-1:0];
    c.page_entry = ent[ENT_W-1:0];
    c.write_access = wr;
    return c;
  endfunction

  task automatic queue_command(cmd_t c, int gap);
    backlog_item_t it;
    it.is_write = 1'b0;
    it.reg_idx = '0;
    it.reg_val = '0;
    it.cmd = c;
    it.gap = gap;
    command_backlog.push_back(it);
  endtask

  task automatic queue_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    backlog_item_t it;
    it.is_write = 1'b1;
    it.reg_idx = idx;
    it.reg_val = val;
    it.cmd = '0;
    it.gap = 0;
    command_backlog.push_back(it);
  endtask

  // driver: presents commands and register writes from the backlog
  always @(posedge clk_i or negedge rst_ni) begin
    logic go;
    cmd_t next_cmd;
    logic we;
    logic [CFG_IDX_W-1:0] widx;
    logic [CFG_DATA_W-1:0] wdata;
    backlog_item_t head;
    if (!rst_ni) begin
      start_i <= 1'b0;
      cmd_i <= '0;
      cfg_we_i <= 1'b0;
      cfg_idx_i <= '0;
      cfg_data_i <= '0;
      gap_count = 0;
      settle_count = 0;
    end else begin
      go = start_i;
      next_cmd = cmd_i;
      we = 1'b0;
      widx = cfg_idx_i;
      wdata = cfg_data_i;
      if (start_i && !busy_o) begin
        predicted_results.push_back(predict_outcome(cmd_i));
        issued_count++;
        go = 1'b0;
      end
      if (!go && command_backlog.size() > 0) begin
        head = command_backlog[0];
        if (head.is_write) begin
          // registers change only once every transaction has been answered
          if (issued_count == received_count && !busy_o && !start_i) settle_count++;
          else settle_count = 0;
          if (settle_count >= SETTLE_CYCLES) begin
            we = 1'b1;
            widx = head.reg_idx;
            wdata = head.reg_val;
            case (head.reg_idx)
              REG_ALGORITHM: modified_clock = head.reg_val[0];
              REG_TABLES: tables_reg = head.reg_val[4:0];
              REG_ENTRIES: entries_reg = head.reg_val;
              default: ;
            endcase
            void'(command_backlog.pop_front());
          end
        end else if (gap_count < head.gap) begin
          gap_count++;
        end else begin
          go = 1'b1;
          next_cmd = head.cmd;
          gap_count = 0;
          void'(command_backlog.pop_front());
        end
      end
      start_i <= go;
      cmd_i <= next_cmd;
      cfg_we_i <= we;
      cfg_idx_i <= widx;
      cfg_data_i <= wdata;
    end
  end

  // monitor: every strobe is matched against the oldest prediction
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && result_valid_o) begin
      if (predicted_results.size() == 0) begin
        $error("result_o: no transaction outstanding, got %h", result_o);
        error_count++;
      end else begin
        want = predicted_results.pop_front();
        if (result_o.victim_found !== want.victim_found) begin
          $error("victim_found: expected %0d, got %0d", want.victim_found,
                 result_o.victim_found);
          error_count++;
        end
        if (result_o.victim_table !== want.victim_table) begin
          $error("victim_table: expected %0d, got %0d", want.victim_table,
                 result_o.victim_table);
          error_count++;
        end
        if (result_o.victim_entry !== want.victim_entry) begin
          $error("victim_entry: expected %0d, got %0d", want.victim_entry,
                 result_o.victim_entry);
          error_count++;
        end
        if (result_o.needs_writeback !== want.needs_writeback) begin
          $error("needs_writeback: expected %0d, got %0d", want.needs_writeback,
                 result_o.needs_writeback);
          error_count++;
        end
        received_count <= received_count + 1;
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Verification failed");
    $finish;
  end

  initial begin
    bit big;
    bit quiet;
    int n_tbl;
    int n_ent;
    int tbl_val;
    int ent_val;
    int items;
    int effective;
    int roll;
    logic alg;
    cmd_t c;

    foreach (page_flags[i]) page_flags[i] = '0;

    // directed: empty select, table edges, ignored and unknown commands
    queue_command(build_cmd(MODE_SELECT, 15, 63, 1'b1), 0);
    queue_command(build_cmd(MODE_TOUCH, 0, 0, 1'b0), 0);
    queue_command(build_cmd(MODE_TOUCH, 0, 63, 1'b1), pick_gap(1'b0));
    queue_command(build_cmd(MODE_TOUCH, 0, 1, 1'b1), 0);
    queue_command(build_cmd(MODE_TOUCH, 15, 63, 1'b1), 0);
    queue_command(build_cmd(MODE_UNKNOWN, 15, 63, 1'b1), 0);
    queue_command(build_cmd(MODE_SELECT, 0, 0, 1'b0), pick_gap(1'b0));
    queue_command(build_cmd(MODE_SELECT, 0, 0, 1'b0), 0);
    queue_command(build_cmd(MODE_RELEASE, 0, 63, 1'b0), 0);
    queue_command(build_cmd(MODE_RELEASE, 0, 5, 1'b1), 0);
    // out-of-range register values clamp to the largest sizes
    queue_register(REG_ALGORITHM, 7'h7f);
    queue_register(REG_TABLES, 7'd31);
    queue_register(REG_ENTRIES, 7'd127);
    queue_register(REG_UNMAPPED, 7'h55);
    queue_command(build_cmd(MODE_TOUCH, 15, 63, 1'b1), 0);
    queue_command(build_cmd(MODE_TOUCH, 7, 10, 1'b0), 0);
    queue_command(build_cmd(MODE_SELECT, 0, 0, 1'b0), 0);
    queue_command(build_cmd(MODE_SELECT, 0, 0, 1'b0), pick_gap(1'b0));
    queue_command(build_cmd(MODE_SELECT, 0, 0, 1'b0), 0);
    queue_command(build_cmd(MODE_TOUCH, 0, 0, 1'b0), 0);
    // zero sizes act as one, leaving the cursor outside the range
    queue_register(REG_TABLES, 7'd0);
    queue_register(REG_ENTRIES, 7'd0);
    queue_command(build_cmd(MODE_TOUCH, 0, 0, 1'b1), 0);
    queue_command(build_cmd(MODE_TOUCH, 0, 1, 1'b0), 0);
    queue_command(build_cmd(MODE_SELECT, 0, 0, 1'b0), 0);
    queue_command(build_cmd(MODE_SELECT, 0, 0, 1'b0), 0);
    queue_command(build_cmd(MODE_RELEASE, 0, 0, 1'b0), 0);
    queue_command(build_cmd(MODE_SELECT, 0, 0, 1'b0), 0);

    // random phases: mostly small page sets, a few at full size
    for (int p = 0; p < PHASES; p++) begin
      big = (p % 6 == 3);
      quiet = ($urandom_range(0, 3) == 0);
      alg = p[0];
      if (big) begin
        n_tbl = PAGE_TABLES;
        n_ent = TABLE_ENTRIES;
        tbl_val = $urandom_range(16, 31);
        ent_val = $urandom_range(64, 127);
        items = 50;
      end else begin
        n_tbl = $urandom_range(1, 4);
        n_ent = $urandom_range(1, 16);
        tbl_val = (n_tbl == 1 && $urandom_range(0, 1)) ? 0 : n_tbl;
        ent_val = (n_ent == 1 && $urandom_range(0, 1)) ? 0 : n_ent;
        items = 125;
      end
      queue_register(REG_ALGORITHM, {6'($urandom), alg});
      queue_register(REG_TABLES, {2'($urandom), 5'(tbl_val)});
      queue_register(REG_ENTRIES, 7'(ent_val));
      effective = 0;
      while (effective < items) begin
        effective++;
        roll = $urandom_range(0, 99);
        c.mode = 2'($urandom_range(0, 3));
        c.page_table = 4'($urandom_range(0, 15));
        c.page_entry = 6'($urandom_range(0, 63));
        c.write_access = 1'($urandom_range(0, 1));
        if (roll < 87) begin
          c.page_table = 4'($urandom_range(0, n_tbl - 1));
          c.page_entry = 6'($urandom_range(0, n_ent - 1));
          if (roll < 45) c.mode = MODE_TOUCH;
          else if (roll < 67) c.mode = MODE_SELECT;
          else c.mode = MODE_RELEASE;
        end
        queue_command(c, pick_gap(quiet));
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample on the falling edge so the driver and monitor updates have settled
    while (command_backlog.size() > 0 || start_i || received_count != issued_count)
      @(negedge clk_i);
    repeat (20) @(posedge clk_i);

    if (error_count == 0 && predicted_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/cpr_pkg.sv
src/cpr_flag_mem.sv
src/cpr_ctrl.sv
src/clock_page_replacement_unit.sv
sim/tb_top.sv
